// ----- hdl/arc_pkg.sv -----
package arc_pkg;

  localparam int MAX_CAP = 64;
  localparam int KEY_W   = 32;
  localparam int DEPTH   = 2 * MAX_CAP;
  localparam int IDX_W   = $clog2(DEPTH);
  localparam int RANK_W  = 7;
  localparam int CAP_W   = 7;
  localparam int SIZE_W  = 8;
  localparam int GRP_N   = 16;
  localparam int GRP_CNT = DEPTH / GRP_N;
  localparam int GIDX_W  = $clog2(GRP_N);
  localparam int GSEL_W  = IDX_W - GIDX_W;

  typedef enum logic [1:0] {LIST_T1, LIST_T2, LIST_B1, LIST_B2} list_t;
  typedef enum logic [1:0] {OP_NONE, OP_UNLINK, OP_PUSH, OP_FLUSH} op_t;
  typedef enum logic [1:0] {Q_KEY, Q_LRU, Q_FREE} qmode_t;

  typedef struct packed {
    op_t               op;
    logic [IDX_W-1:0]  idx;
    list_t             tag;
    logic [RANK_W-1:0] rank;
    logic [KEY_W-1:0]  key;
  } cmd_t;

  typedef struct packed {
    qmode_t            mode;
    logic [KEY_W-1:0]  key;
    list_t             tag;
    logic [RANK_W-1:0] rank;
  } query_t;

  typedef struct packed {
    logic [KEY_W-1:0]  key;
    list_t             tag;
    logic [RANK_W-1:0] rank;
  } entry_t;

  typedef enum logic [4:0] {
    S_IDLE, S_W1, S_W2, S_DISP, S_HITPUSH, S_DIV, S_GREFIND, S_GUNL, S_GPUSH,
    S_DEL, S_DELU, S_REP, S_REPU, S_REPP, S_FREE, S_FREEP, S_DONE
  } state_t;

endpackage

// ----- hdl/arc_cell.sv -----
module arc_cell (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic [arc_pkg::IDX_W-1:0] cell_idx,
  input  arc_pkg::cmd_t            cmd,
  input  arc_pkg::query_t          query,
  output logic                     match,
  output arc_pkg::entry_t          entry
);

  logic                        valid_r;
  logic [arc_pkg::KEY_W-1:0]   key_r;
  arc_pkg::list_t              tag_r;
  logic [arc_pkg::RANK_W-1:0]  rank_r;

  // compare this entry against the broadcast query
  always_comb begin
    case (query.mode)
      arc_pkg::Q_KEY:  match = valid_r && (key_r == query.key);
      arc_pkg::Q_LRU:  match = valid_r && (tag_r == query.tag) && (rank_r == query.rank);
      arc_pkg::Q_FREE: match = !valid_r;
      default:         match = 1'b0;
    endcase
  end

  assign entry.key  = key_r;
  assign entry.tag  = tag_r;
  assign entry.rank = rank_r;

  // apply the broadcast list operation to this entry
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      tag_r   <= arc_pkg::LIST_T1;
      rank_r  <= '0;
    end else begin
      case (cmd.op)
        arc_pkg::OP_UNLINK: begin
          if (cmd.idx == cell_idx) begin
            valid_r <= 1'b0;
          end else if (valid_r && tag_r == cmd.tag && rank_r > cmd.rank) begin
            rank_r <= rank_r - 1'b1;
          end
        end
        arc_pkg::OP_PUSH: begin
          if (cmd.idx == cell_idx) begin
            valid_r <= 1'b1;
            key_r   <= cmd.key;
            tag_r   <= cmd.tag;
            rank_r  <= '0;
          end else if (valid_r && tag_r == cmd.tag) begin
            rank_r <= rank_r + 1'b1;
          end
        end
        arc_pkg::OP_FLUSH: valid_r <= 1'b0;
        default: ;
      endcase
    end
  end

endmodule

// ----- hdl/arc_grp.sv -----
module arc_grp (
  input  logic                       clk,
  input  logic [arc_pkg::GRP_N-1:0]  match,
  input  arc_pkg::entry_t            ent [arc_pkg::GRP_N],
  output logic                       found_r,
  output logic [arc_pkg::GIDX_W-1:0] lidx_r,
  output arc_pkg::entry_t            ent_r
);

  logic                       found_nxt;
  logic [arc_pkg::GIDX_W-1:0] lidx_nxt;
  arc_pkg::entry_t            ent_nxt;

  // pick the lowest matching entry of the group
  always_comb begin
    found_nxt = 1'b0;
    lidx_nxt  = '0;
    ent_nxt   = ent[0];
    for (int i = arc_pkg::GRP_N - 1; i >= 0; i--) begin
      if (match[i]) begin
        found_nxt = 1'b1;
        lidx_nxt  = arc_pkg::GIDX_W'(i);
        ent_nxt   = ent[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    found_r <= found_nxt;
    lidx_r  <= lidx_nxt;
    ent_r   <= ent_nxt;
  end

endmodule

// ----- hdl/arc_div.sv -----
module arc_div (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [arc_pkg::SIZE_W-1:0] num,
  input  logic [arc_pkg::SIZE_W-1:0] den,
  output logic                      done_r,
  output logic [arc_pkg::SIZE_W-1:0] quo_r
);

  localparam int CNT_W = $clog2(arc_pkg::SIZE_W);

  logic                       busy_r;
  logic [CNT_W-1:0]           cnt_r;
  logic [arc_pkg::SIZE_W:0]   rem_r;
  logic [arc_pkg::SIZE_W-1:0] den_r;
  logic [arc_pkg::SIZE_W:0]   rem_sh;
  logic                       ge;

  // one restoring step per cycle
  always_comb begin
    rem_sh = {rem_r[arc_pkg::SIZE_W-1:0], quo_r[arc_pkg::SIZE_W-1]};
    ge     = rem_sh >= {1'b0, den_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= '0;
      rem_r  <= '0;
      quo_r  <= num;
      den_r  <= den;
    end else if (busy_r) begin
      rem_r <= ge ? rem_sh - {1'b0, den_r} : rem_sh;
      quo_r <= {quo_r[arc_pkg::SIZE_W-2:0], ge};
      cnt_r <= cnt_r + 1'b1;
      if (cnt_r == CNT_W'(arc_pkg::SIZE_W - 1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end else begin
      done_r <= 1'b0;
    end
  end

endmodule

// ----- hdl/adaptive_replacement_cache_policy_core.sv -----
// ARC replacement policy engine. The directory is a row of 128 cells, one per
// tracked key, each holding its key, list tag (T1, T2, B1, B2) and recency
// rank; list operations are broadcast to every cell at once, and a lookup
// goes through a two-stage registered priority tree. A new item is taken
// only once the previous one is finished, in_stall being high till then. A
// plain miss may delete a ghost and demote a resident key, each of which
// adds a lookup, and a ghost hit waits on an 8-step serial divide for the
// step of p. Cycles in which the result register is held by out_stall delay
// the next acceptance too. A capacity write flushes all lists and p.
module adaptive_replacement_cache_policy_core (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [arc_pkg::KEY_W-1:0]   in_address,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic                        out_miss,
  output logic                        out_evicted_valid,
  output logic [arc_pkg::KEY_W-1:0]   out_evicted_address,
  output logic [31:0]                 out_accesses,
  output logic [31:0]                 out_misses,
  input  logic                        cfg_write_en,
  input  logic [arc_pkg::CAP_W-1:0]   cfg_write_data
);

  arc_pkg::state_t            state_r, state_nxt, ret_r, ret_nxt;
  arc_pkg::state_t            rep_ret_r, rep_ret_nxt, del_ret_r, del_ret_nxt;
  arc_pkg::list_t             del_t_r, del_t_nxt, rep_src_r, rep_src_nxt;
  logic                       del_ev_r, del_ev_nxt;
  logic                       hitb2_r, hitb2_nxt, inb1_r, inb1_nxt, dz_r, dz_nxt;
  logic [arc_pkg::KEY_W-1:0]  key_r, key_nxt, evk_r, evk_nxt;
  logic                       ev_r, ev_nxt, missf_r, missf_nxt;
  arc_pkg::query_t            q_r, q_nxt;
  logic [arc_pkg::SIZE_W-1:0] sz_r [4];
  logic [arc_pkg::SIZE_W-1:0] sz_nxt [4];
  logic [arc_pkg::CAP_W-1:0]  p_r, p_nxt, cap_r, cap_nxt;
  logic [31:0]                acc_r, acc_nxt, mis_r, mis_nxt;
  logic                       out_valid_r, out_valid_nxt;
  logic                       out_miss_r, out_miss_nxt, out_ev_r, out_ev_nxt;
  logic [arc_pkg::KEY_W-1:0]  out_evk_r, out_evk_nxt;
  logic [31:0]                out_acc_r, out_acc_nxt, out_mis_r, out_mis_nxt;
  arc_pkg::cmd_t              cmd;

  logic                       div_start, div_done;
  logic [arc_pkg::SIZE_W-1:0] div_num, div_den, div_quo, delta;
  logic [arc_pkg::SIZE_W:0]   t1b1;
  logic [arc_pkg::SIZE_W+1:0] total;
  logic                       use_t1;
  arc_pkg::list_t             src;
  logic [arc_pkg::CAP_W+1:0]  psum;

  // directory cells and lookup tree
  logic [arc_pkg::DEPTH-1:0]   cell_match;
  arc_pkg::entry_t             cell_ent [arc_pkg::DEPTH];
  logic [arc_pkg::GRP_CNT-1:0] g_found;
  logic [arc_pkg::GIDX_W-1:0]  g_lidx [arc_pkg::GRP_CNT];
  arc_pkg::entry_t             g_ent [arc_pkg::GRP_CNT];
  logic                        f_found_r, f_found_nxt;
  logic [arc_pkg::IDX_W-1:0]   f_idx_r, f_idx_nxt;
  arc_pkg::entry_t             f_ent_r, f_ent_nxt;

  for (genvar i = 0; i < arc_pkg::DEPTH; i++) begin : g_cell
    arc_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .cell_idx (arc_pkg::IDX_W'(i)),
      .cmd      (cmd),
      .query    (q_r),
      .match    (cell_match[i]),
      .entry    (cell_ent[i])
    );
  end

  for (genvar g = 0; g < arc_pkg::GRP_CNT; g++) begin : g_grp
    arc_grp u_grp (
      .clk     (clk),
      .match   (cell_match[g*arc_pkg::GRP_N +: arc_pkg::GRP_N]),
      .ent     (cell_ent[g*arc_pkg::GRP_N +: arc_pkg::GRP_N]),
      .found_r (g_found[g]),
      .lidx_r  (g_lidx[g]),
      .ent_r   (g_ent[g])
    );
  end

  // final stage of the lookup tree: pick the lowest matching group
  always_comb begin
    f_found_nxt = 1'b0;
    f_idx_nxt   = '0;
    f_ent_nxt   = g_ent[0];
    for (int g = arc_pkg::GRP_CNT - 1; g >= 0; g--) begin
      if (g_found[g]) begin
        f_found_nxt = 1'b1;
        f_idx_nxt   = {arc_pkg::GSEL_W'(g), g_lidx[g]};
        f_ent_nxt   = g_ent[g];
      end
    end
  end

  always_ff @(posedge clk) begin
    f_found_r <= f_found_nxt;
    f_idx_r   <= f_idx_nxt;
    f_ent_r   <= f_ent_nxt;
  end

  arc_div u_div (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (div_start),
    .num    (div_num),
    .den    (div_den),
    .done_r (div_done),
    .quo_r  (div_quo)
  );

  // next state and datapath
  always_comb begin
    state_nxt   = state_r;
    ret_nxt     = ret_r;
    rep_ret_nxt = rep_ret_r;
    del_ret_nxt = del_ret_r;
    del_t_nxt   = del_t_r;
    rep_src_nxt = rep_src_r;
    del_ev_nxt  = del_ev_r;
    hitb2_nxt   = hitb2_r;
    inb1_nxt    = inb1_r;
    dz_nxt      = dz_r;
    key_nxt     = key_r;
    evk_nxt     = evk_r;
    ev_nxt      = ev_r;
    missf_nxt   = missf_r;
    q_nxt       = q_r;
    p_nxt       = p_r;
    cap_nxt     = cap_r;
    acc_nxt     = acc_r;
    mis_nxt     = mis_r;
    sz_nxt      = sz_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_miss_nxt  = out_miss_r;
    out_ev_nxt    = out_ev_r;
    out_evk_nxt   = out_evk_r;
    out_acc_nxt   = out_acc_r;
    out_mis_nxt   = out_mis_r;
    cmd         = '0;
    div_start   = 1'b0;
    div_num     = sz_r[arc_pkg::LIST_B2];
    div_den     = sz_r[arc_pkg::LIST_B1];
    delta       = '0;
    psum        = '0;
    in_stall    = state_r != arc_pkg::S_IDLE;
    t1b1  = {1'b0, sz_r[arc_pkg::LIST_T1]} + {1'b0, sz_r[arc_pkg::LIST_B1]};
    total = {2'b0, sz_r[arc_pkg::LIST_T1]} + {2'b0, sz_r[arc_pkg::LIST_T2]}
          + {2'b0, sz_r[arc_pkg::LIST_B1]} + {2'b0, sz_r[arc_pkg::LIST_B2]};
    use_t1 = sz_r[arc_pkg::LIST_T1] != '0 &&
             (sz_r[arc_pkg::LIST_T1] > {1'b0, p_r} ||
              (hitb2_r && sz_r[arc_pkg::LIST_T1] == {1'b0, p_r}));
    if (!use_t1 && sz_r[arc_pkg::LIST_T2] == '0) begin
      use_t1 = sz_r[arc_pkg::LIST_T1] != '0;
    end
    src = use_t1 ? arc_pkg::LIST_T1 : arc_pkg::LIST_T2;

    case (state_r)
      arc_pkg::S_IDLE: begin
        if (in_valid) begin
          key_nxt   = in_address;
          ev_nxt    = 1'b0;
          evk_nxt   = '0;
          missf_nxt = 1'b0;
          acc_nxt   = acc_r + 1'b1;
          q_nxt     = '{arc_pkg::Q_KEY, in_address, arc_pkg::LIST_T1, '0};
          ret_nxt   = arc_pkg::S_DISP;
          state_nxt = arc_pkg::S_W1;
        end
      end
      arc_pkg::S_W1: state_nxt = arc_pkg::S_W2;
      arc_pkg::S_W2: state_nxt = ret_r;
      arc_pkg::S_DISP: begin
        if (f_found_r && (f_ent_r.tag == arc_pkg::LIST_T1 ||
                          f_ent_r.tag == arc_pkg::LIST_T2)) begin
          cmd       = '{arc_pkg::OP_UNLINK, f_idx_r, f_ent_r.tag, f_ent_r.rank, key_r};
          state_nxt = arc_pkg::S_HITPUSH;
        end else if (f_found_r) begin
          // ghost hit: step size from the ratio of ghost list sizes
          mis_nxt   = mis_r + 1'b1;
          missf_nxt = 1'b1;
          inb1_nxt  = f_ent_r.tag == arc_pkg::LIST_B1;
          if (f_ent_r.tag == arc_pkg::LIST_B1) begin
            div_num = sz_r[arc_pkg::LIST_B2];
            div_den = sz_r[arc_pkg::LIST_B1];
          end else begin
            div_num = sz_r[arc_pkg::LIST_B1];
            div_den = sz_r[arc_pkg::LIST_B2];
          end
          dz_nxt    = div_den == '0;
          div_start = 1'b1;
          state_nxt = arc_pkg::S_DIV;
        end else begin
          mis_nxt     = mis_r + 1'b1;
          missf_nxt   = 1'b1;
          hitb2_nxt   = 1'b0;
          rep_ret_nxt = arc_pkg::S_FREE;
          if (t1b1 >= {2'b0, cap_r}) begin
            if ({1'b0, sz_r[arc_pkg::LIST_T1]} < {2'b0, cap_r}) begin
              del_t_nxt   = arc_pkg::LIST_B1;
              del_ev_nxt  = 1'b0;
              del_ret_nxt = arc_pkg::S_REP;
            end else begin
              del_t_nxt   = arc_pkg::LIST_T1;
              del_ev_nxt  = 1'b1;
              del_ret_nxt = arc_pkg::S_FREE;
            end
            state_nxt = arc_pkg::S_DEL;
          end else if (total >= {3'b0, cap_r}) begin
            if (total >= {2'b0, cap_r, 1'b0}) begin
              del_t_nxt   = arc_pkg::LIST_B2;
              del_ev_nxt  = 1'b0;
              del_ret_nxt = arc_pkg::S_REP;
              state_nxt   = arc_pkg::S_DEL;
            end else begin
              state_nxt = arc_pkg::S_REP;
            end
          end else begin
            state_nxt = arc_pkg::S_FREE;
          end
        end
      end
      arc_pkg::S_HITPUSH: begin
        cmd       = '{arc_pkg::OP_PUSH, f_idx_r, arc_pkg::LIST_T2, '0, key_r};
        state_nxt = arc_pkg::S_DONE;
      end
      arc_pkg::S_DIV: begin
        if (div_done) begin
          delta = (dz_r || div_quo == '0) ? arc_pkg::SIZE_W'(1) : div_quo;
          if (inb1_r) begin
            psum  = {2'b0, p_r} + {1'b0, delta};
            p_nxt = (psum > {2'b0, cap_r}) ? cap_r : psum[arc_pkg::CAP_W-1:0];
          end else begin
            p_nxt = ({1'b0, p_r} > delta) ? p_r - delta[arc_pkg::CAP_W-1:0] : '0;
          end
          hitb2_nxt   = !inb1_r;
          rep_ret_nxt = arc_pkg::S_GREFIND;
          state_nxt   = arc_pkg::S_REP;
        end
      end
      arc_pkg::S_GREFIND: begin
        q_nxt     = '{arc_pkg::Q_KEY, key_r, arc_pkg::LIST_T1, '0};
        ret_nxt   = arc_pkg::S_GUNL;
        state_nxt = arc_pkg::S_W1;
      end
      arc_pkg::S_GUNL: begin
        if (f_found_r) begin
          cmd       = '{arc_pkg::OP_UNLINK, f_idx_r, f_ent_r.tag, f_ent_r.rank, key_r};
          state_nxt = arc_pkg::S_GPUSH;
        end else begin
          state_nxt = arc_pkg::S_DONE;
        end
      end
      arc_pkg::S_GPUSH: begin
        cmd       = '{arc_pkg::OP_PUSH, f_idx_r, arc_pkg::LIST_T2, '0, key_r};
        state_nxt = arc_pkg::S_DONE;
      end
      arc_pkg::S_DEL: begin
        if (sz_r[del_t_r] == '0) begin
          state_nxt = del_ret_r;
        end else begin
          q_nxt     = '{arc_pkg::Q_LRU, key_r, del_t_r,
                        arc_pkg::RANK_W'(sz_r[del_t_r] - 1'b1)};
          ret_nxt   = arc_pkg::S_DELU;
          state_nxt = arc_pkg::S_W1;
        end
      end
      arc_pkg::S_DELU: begin
        if (f_found_r) begin
          cmd = '{arc_pkg::OP_UNLINK, f_idx_r, f_ent_r.tag, f_ent_r.rank, key_r};
          if (del_ev_r) begin
            ev_nxt  = 1'b1;
            evk_nxt = f_ent_r.key;
          end
        end
        state_nxt = del_ret_r;
      end
      arc_pkg::S_REP: begin
        if (sz_r[src] == '0) begin
          state_nxt = rep_ret_r;
        end else begin
          rep_src_nxt = src;
          q_nxt       = '{arc_pkg::Q_LRU, key_r, src,
                          arc_pkg::RANK_W'(sz_r[src] - 1'b1)};
          ret_nxt     = arc_pkg::S_REPU;
          state_nxt   = arc_pkg::S_W1;
        end
      end
      arc_pkg::S_REPU: begin
        if (f_found_r) begin
          cmd       = '{arc_pkg::OP_UNLINK, f_idx_r, f_ent_r.tag, f_ent_r.rank, key_r};
          ev_nxt    = 1'b1;
          evk_nxt   = f_ent_r.key;
          state_nxt = arc_pkg::S_REPP;
        end else begin
          state_nxt = rep_ret_r;
        end
      end
      arc_pkg::S_REPP: begin
        // demote the victim to the matching ghost list
        cmd = '{arc_pkg::OP_PUSH, f_idx_r,
                (rep_src_r == arc_pkg::LIST_T1) ? arc_pkg::LIST_B1 : arc_pkg::LIST_B2,
                '0, f_ent_r.key};
        state_nxt = rep_ret_r;
      end
      arc_pkg::S_FREE: begin
        q_nxt     = '{arc_pkg::Q_FREE, key_r, arc_pkg::LIST_T1, '0};
        ret_nxt   = arc_pkg::S_FREEP;
        state_nxt = arc_pkg::S_W1;
      end
      arc_pkg::S_FREEP: begin
        if (f_found_r) begin
          cmd = '{arc_pkg::OP_PUSH, f_idx_r, arc_pkg::LIST_T1, '0, key_r};
        end
        state_nxt = arc_pkg::S_DONE;
      end
      arc_pkg::S_DONE: begin
        // hold until the output register is free
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_miss_nxt  = missf_r;
          out_ev_nxt    = ev_r;
          out_evk_nxt   = ev_r ? evk_r : '0;
          out_acc_nxt   = acc_r;
          out_mis_nxt   = mis_r;
          state_nxt     = arc_pkg::S_IDLE;
        end
      end
      default: state_nxt = arc_pkg::S_IDLE;
    endcase

    // capacity write flushes the directory and p
    if (cfg_write_en) begin
      cmd.op = arc_pkg::OP_FLUSH;
      p_nxt  = '0;
      if (cfg_write_data == '0) begin
        cap_nxt = arc_pkg::CAP_W'(1);
      end else if (cfg_write_data > arc_pkg::CAP_W'(arc_pkg::MAX_CAP)) begin
        cap_nxt = arc_pkg::CAP_W'(arc_pkg::MAX_CAP);
      end else begin
        cap_nxt = cfg_write_data;
      end
    end

    // track list sizes alongside the cell operations
    case (cmd.op)
      arc_pkg::OP_UNLINK: begin
        if (sz_r[cmd.tag] != '0) begin
          sz_nxt[cmd.tag] = sz_r[cmd.tag] - 1'b1;
        end
      end
      arc_pkg::OP_PUSH:  sz_nxt[cmd.tag] = sz_r[cmd.tag] + 1'b1;
      arc_pkg::OP_FLUSH: for (int t = 0; t < 4; t++) sz_nxt[t] = '0;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= arc_pkg::S_IDLE;
      ret_r       <= arc_pkg::S_IDLE;
      rep_ret_r   <= arc_pkg::S_IDLE;
      del_ret_r   <= arc_pkg::S_IDLE;
      p_r         <= '0;
      cap_r       <= arc_pkg::CAP_W'(arc_pkg::MAX_CAP);
      acc_r       <= '0;
      mis_r       <= '0;
      out_valid_r <= 1'b0;
      q_r         <= '{arc_pkg::Q_FREE, '0, arc_pkg::LIST_T1, '0};
      for (int t = 0; t < 4; t++) sz_r[t] <= '0;
    end else begin
      state_r     <= state_nxt;
      ret_r       <= ret_nxt;
      rep_ret_r   <= rep_ret_nxt;
      del_ret_r   <= del_ret_nxt;
      p_r         <= p_nxt;
      cap_r       <= cap_nxt;
      acc_r       <= acc_nxt;
      mis_r       <= mis_nxt;
      out_valid_r <= out_valid_nxt;
      q_r         <= q_nxt;
      sz_r        <= sz_nxt;
    end
  end

  always_ff @(posedge clk) begin
    del_t_r   <= del_t_nxt;
    rep_src_r <= rep_src_nxt;
    del_ev_r  <= del_ev_nxt;
    hitb2_r   <= hitb2_nxt;
    inb1_r    <= inb1_nxt;
    dz_r      <= dz_nxt;
    key_r     <= key_nxt;
    evk_r     <= evk_nxt;
    ev_r      <= ev_nxt;
    missf_r   <= missf_nxt;
    out_miss_r <= out_miss_nxt;
    out_ev_r   <= out_ev_nxt;
    out_evk_r  <= out_evk_nxt;
    out_acc_r  <= out_acc_nxt;
    out_mis_r  <= out_mis_nxt;
  end

  assign out_valid           = out_valid_r;
  assign out_miss            = out_miss_r;
  assign out_evicted_valid   = out_ev_r;
  assign out_evicted_address = out_evk_r;
  assign out_accesses        = out_acc_r;
  assign out_misses          = out_mis_r;

  a_p_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    p_r <= cap_r)
    else $error("target p above capacity");

  a_resident_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == arc_pkg::S_IDLE |->
      ({1'b0, sz_r[arc_pkg::LIST_T1]} + {1'b0, sz_r[arc_pkg::LIST_T2]}) <= {2'b0, cap_r})
    else $error("resident lists exceed capacity");

  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> state_r != arc_pkg::S_IDLE)
    else $error("accepted item not processed");

endmodule

// ----- tb/sv/adaptive_replacement_cache_policy_core_tb.sv -----
`timescale 1ns / 100ps

module adaptive_replacement_cache_policy_core_tb;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int SETTLE_CYCLES  = 40;
  localparam int ITEMS_PER_PHASE = 300;

  typedef struct {
    logic        miss;
    logic        ev_valid;
    logic [31:0] ev_addr;
    logic [31:0] acc_cnt;
    logic [31:0] miss_cnt;
  } verdict_t;

  typedef struct {
    bit          set_cap;
    int          cap_val;
    logic [31:0] addr;
    bit          typed;
    verdict_t    want;
  } stim_row_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [31:0] in_address;
  logic        out_valid;
  logic        out_stall;
  logic        out_miss;
  logic        out_evicted_valid;
  logic [31:0] out_evicted_address;
  logic [31:0] out_accesses;
  logic [31:0] out_misses;
  logic        cfg_write_en;
  logic [arc_pkg::CAP_W-1:0] cfg_write_data;

  // ARC shadow state
  logic [31:0]     arc_key [arc_pkg::DEPTH];
  bit              arc_live [arc_pkg::DEPTH];
  arc_pkg::list_t  arc_tag [arc_pkg::DEPTH];
  int              arc_rank [arc_pkg::DEPTH];
  int              arc_len [4];
  int              arc_p;
  int              arc_cap;
  logic [31:0]     arc_hits;
  logic [31:0]     arc_misses;
  bit              arc_ev;
  logic [31:0]     arc_ev_key;

  verdict_t pending_verdicts[$];
  int       fail_cnt;
  int       result_cnt;
  int       ghost_hit_cnt;
  int       quiet_cycles;
  int       idle_mode;       // 0 none, 1 sender, 2 receiver, 3 both
  bit       hold_req;
  int       hold_left;

  adaptive_replacement_cache_policy_core u_top (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_address          (in_address),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_miss            (out_miss),
    .out_evicted_valid   (out_evicted_valid),
    .out_evicted_address (out_evicted_address),
    .out_accesses        (out_accesses),
    .out_misses          (out_misses),
    .cfg_write_en        (cfg_write_en),
    .cfg_write_data      (cfg_write_data)
  );

  always #2 clk = ~clk;

  // ---------------- shadow ARC ----------------
  function automatic void arc_flush();
    for (int i = 0; i < arc_pkg::DEPTH; i++) begin
      arc_live[i] = 0;
      arc_tag[i]  = arc_pkg::LIST_T1;
      arc_rank[i] = 0;
      arc_key[i]  = '0;
    end
    for (int t = 0; t < 4; t++) arc_len[t] = 0;
    arc_p = 0;
  endfunction

  function automatic int arc_find_key(logic [31:0] k);
    for (int i = 0; i < arc_pkg::DEPTH; i++)
      if (arc_live[i] && arc_key[i] == k) return i;
    return -1;
  endfunction

  function automatic int arc_find_lru(arc_pkg::list_t t);
    if (arc_len[t] == 0) return -1;
    for (int i = 0; i < arc_pkg::DEPTH; i++)
      if (arc_live[i] && arc_tag[i] == t && arc_rank[i] == arc_len[t] - 1) return i;
    return -1;
  endfunction

  function automatic void arc_unlink(int i);
    arc_pkg::list_t t;
    t = arc_tag[i];
    for (int j = 0; j < arc_pkg::DEPTH; j++)
      if (arc_live[j] && arc_tag[j] == t && arc_rank[j] > arc_rank[i]) arc_rank[j]--;
    if (arc_len[t] > 0) arc_len[t]--;
    arc_live[i] = 0;
  endfunction

  function automatic void arc_push_mru(int i, arc_pkg::list_t t, logic [31:0] k);
    for (int j = 0; j < arc_pkg::DEPTH; j++)
      if (arc_live[j] && arc_tag[j] == t) arc_rank[j]++;
    arc_key[i]  = k;
    arc_live[i] = 1;
    arc_tag[i]  = t;
    arc_rank[i] = 0;
    arc_len[t]++;
  endfunction

  function automatic void arc_drop_lru(arc_pkg::list_t t);
    int i;
    i = arc_find_lru(t);
    if (i >= 0) arc_unlink(i);
  endfunction

  // demote LRU of T1 or T2 into its ghost list
  function automatic void arc_demote(bit hit_b2);
    int    t1;
    bit    from_t1;
    int    i;
    logic [31:0] k;
    t1 = arc_len[arc_pkg::LIST_T1];
    from_t1 = t1 >= 1 && (t1 > arc_p || (hit_b2 && t1 == arc_p));
    if (!from_t1 && arc_len[arc_pkg::LIST_T2] == 0) from_t1 = t1 >= 1;
    i = arc_find_lru(from_t1 ? arc_pkg::LIST_T1 : arc_pkg::LIST_T2);
    if (i < 0) return;
    k = arc_key[i];
    arc_unlink(i);
    arc_push_mru(i, from_t1 ? arc_pkg::LIST_B1 : arc_pkg::LIST_B2, k);
    arc_ev     = 1;
    arc_ev_key = k;
  endfunction

  function automatic void arc_set_capacity(int v);
    arc_cap = (v < 1) ? 1 : (v > arc_pkg::MAX_CAP) ? arc_pkg::MAX_CAP : v;
    arc_flush();
  endfunction

  function automatic verdict_t arc_access(logic [31:0] k);
    verdict_t r;
    int  i, slot, num, den, delta, total, v;
    bit  is_miss, in_b1;
    i = arc_find_key(k);
    arc_ev = 0;
    arc_ev_key = '0;
    if (i >= 0 && (arc_tag[i] == arc_pkg::LIST_T1 || arc_tag[i] == arc_pkg::LIST_T2)) begin
      is_miss = 0;
      arc_hits++;
      arc_unlink(i);
      arc_push_mru(i, arc_pkg::LIST_T2, k);
    end else if (i >= 0) begin
      ghost_hit_cnt++;
      in_b1 = arc_tag[i] == arc_pkg::LIST_B1;
      num = in_b1 ? arc_len[arc_pkg::LIST_B2] : arc_len[arc_pkg::LIST_B1];
      den = in_b1 ? arc_len[arc_pkg::LIST_B1] : arc_len[arc_pkg::LIST_B2];
      delta = (den != 0) ? num / den : 1;
      if (delta < 1) delta = 1;
      is_miss = 1;
      arc_misses++;
      if (in_b1) arc_p = (arc_p + delta > arc_cap) ? arc_cap : arc_p + delta;
      else       arc_p = (arc_p > delta) ? arc_p - delta : 0;
      arc_demote(!in_b1);
      slot = arc_find_key(k);
      if (slot >= 0) begin
        arc_unlink(slot);
        arc_push_mru(slot, arc_pkg::LIST_T2, k);
      end
    end else begin
      is_miss = 1;
      arc_misses++;
      total = arc_len[0] + arc_len[1] + arc_len[2] + arc_len[3];
      if (arc_len[arc_pkg::LIST_T1] + arc_len[arc_pkg::LIST_B1] >= arc_cap) begin
        if (arc_len[arc_pkg::LIST_T1] < arc_cap) begin
          arc_drop_lru(arc_pkg::LIST_B1);
          arc_demote(0);
        end else begin
          v = arc_find_lru(arc_pkg::LIST_T1);
          if (v >= 0) begin
            arc_ev     = 1;
            arc_ev_key = arc_key[v];
            arc_unlink(v);
          end
        end
      end else if (total >= arc_cap) begin
        if (total >= 2 * arc_cap) arc_drop_lru(arc_pkg::LIST_B2);
        arc_demote(0);
      end
      slot = -1;
      for (int j = arc_pkg::DEPTH - 1; j >= 0; j--) if (!arc_live[j]) slot = j;
      if (slot >= 0) arc_push_mru(slot, arc_pkg::LIST_T1, k);
    end
    r.miss     = is_miss;
    r.ev_valid = arc_ev;
    r.ev_addr  = arc_ev ? arc_ev_key : '0;
    r.acc_cnt  = arc_hits + arc_misses;
    r.miss_cnt = arc_misses;
    return r;
  endfunction

  // ---------------- result side ----------------
  always @(posedge clk) begin
    verdict_t w;
    if (rst_n && out_valid && !out_stall) begin
      quiet_cycles <= 0;
      result_cnt++;
      if (pending_verdicts.size() == 0) begin
        fail_cnt++;
        $error("result item with no expectation waiting");
      end else begin
        w = pending_verdicts.pop_front();
        if (out_miss !== w.miss) begin
          fail_cnt++;
          $error("miss: expected %0d, got %0d", w.miss, out_miss);
        end
        if (out_evicted_valid !== w.ev_valid) begin
          fail_cnt++;
          $error("evicted_valid: expected %0d, got %0d", w.ev_valid, out_evicted_valid);
        end
        if (out_evicted_address !== w.ev_addr) begin
          fail_cnt++;
          $error("evicted_address: expected %h, got %h", w.ev_addr, out_evicted_address);
        end
        if (out_accesses !== w.acc_cnt) begin
          fail_cnt++;
          $error("accesses: expected %0d, got %0d", w.acc_cnt, out_accesses);
        end
        if (out_misses !== w.miss_cnt) begin
          fail_cnt++;
          $error("misses: expected %0d, got %0d", w.miss_cnt, out_misses);
        end
      end
    end else if (rst_n && !(in_valid && !in_stall)) begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // stall pattern, with a long hold-off on request
  always @(posedge clk) begin
    if (hold_req && hold_left == 0) begin
      hold_left = 400;
      hold_req  = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (idle_mode == 2) begin
      out_stall <= ($urandom_range(99) < 52);
    end else if (idle_mode == 3) begin
      out_stall <= ($urandom_range(99) < 8);
    end else begin
      out_stall <= 1'b0;
    end
  end

  // watchdog on cycles since the last result in which no item was accepted
  always @(posedge clk) begin
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // ---------------- input side ----------------
  task automatic send_access(logic [31:0] a, bit typed, verdict_t want);
    verdict_t got;
    in_valid   <= 1'b1;
    in_address <= a;
    do @(posedge clk); while (in_stall);
    got = arc_access(a);
    pending_verdicts.push_back(typed ? want : got);
    if ((idle_mode == 1 && $urandom_range(99) < 52) ||
        (idle_mode == 3 && $urandom_range(99) < 8)) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_verdicts.size() != 0) @(posedge clk);
  endtask

  task automatic write_capacity(int v);
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_write_en   <= 1'b1;
    cfg_write_data <= v[arc_pkg::CAP_W-1:0];
    @(posedge clk);
    arc_set_capacity(v);
    cfg_write_en <= 1'b0;
  endtask

  function automatic verdict_t mk(logic m, logic ev, logic [31:0] ea, int ac, int mc);
    verdict_t r;
    r.miss = m; r.ev_valid = ev; r.ev_addr = ea; r.acc_cnt = ac; r.miss_cnt = mc;
    return r;
  endfunction

  initial begin
    stim_row_t   rows[$];
    verdict_t    none;
    logic [31:0] base;
    int          caps[6];
    int          modes[6];
    int          pool;
    logic [31:0] a;

    clk = 0; rst_n = 0; in_valid = 0; in_address = '0; out_stall = 0;
    cfg_write_en = 0; cfg_write_data = '0;
    fail_cnt = 0; result_cnt = 0; ghost_hit_cnt = 0; quiet_cycles = 0;
    idle_mode = 0; hold_req = 0; hold_left = 0;
    arc_hits = '0; arc_misses = '0;
    arc_set_capacity(64);
    none = mk(0, 0, 0, 0, 0);

    // directed rows: extremes of key, hits, tiny capacities, saturation
    rows.push_back('{0, 0, 32'h0000_0000, 1, mk(1, 0, 0, 1, 1)});
    rows.push_back('{0, 0, 32'hFFFF_FFFF, 1, mk(1, 0, 0, 2, 2)});
    rows.push_back('{0, 0, 32'h0000_0000, 1, mk(0, 0, 0, 3, 2)});
    rows.push_back('{0, 0, 32'hFFFF_FFFF, 1, mk(0, 0, 0, 4, 2)});
    rows.push_back('{1, 0, 32'h0000_0001, 0, none});   // zero saturates to one
    rows.push_back('{0, 0, 32'h8000_0000, 0, none});
    rows.push_back('{0, 0, 32'h0000_0001, 0, none});   // miss again: evicted from T1 without a ghost
    rows.push_back('{0, 0, 32'h8000_0000, 0, none});
    rows.push_back('{0, 0, 32'h0000_0001, 0, none});
    rows.push_back('{1, 2, 32'h1111_1111, 0, none});
    rows.push_back('{0, 0, 32'h2222_2222, 0, none});
    rows.push_back('{0, 0, 32'h2222_2222, 0, none});   // T1 to T2
    rows.push_back('{0, 0, 32'h3333_3333, 0, none});
    rows.push_back('{0, 0, 32'h4444_4444, 0, none});
    rows.push_back('{0, 0, 32'h2222_2222, 0, none});   // hit in T2
    rows.push_back('{0, 0, 32'h1111_1111, 0, none});
    rows.push_back('{0, 0, 32'h5555_5555, 0, none});
    rows.push_back('{0, 0, 32'h3333_3333, 0, none});
    rows.push_back('{1, 127, 32'hDEAD_BEEF, 0, none}); // saturates to the maximum
    rows.push_back('{0, 0, 32'hDEAD_BEEF, 0, none});

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (rows[r]) begin
      if (rows[r].set_cap) write_capacity(rows[r].cap_val);
      send_access(rows[r].addr, rows[r].typed, rows[r].want);
    end

    // random phases: keys mostly from a small pool so that hits and ghost hits occur
    caps  = '{1, 64, 4, 0, 127, 9};
    modes = '{0, 2, 1, 3, 0, 2};
    for (int ph = 0; ph < 6; ph++) begin
      write_capacity(ph == 5 ? $urandom_range(2, 63) : caps[ph]);
      idle_mode = modes[ph];
      base = $urandom;
      pool = 3 * arc_cap + 2;
      if (ph == 1) hold_req = 1;
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        if ($urandom_range(99) < 85) a = base ^ $urandom_range(0, pool);
        else                         a = $urandom;
        if (ph == 2 && n == ITEMS_PER_PHASE / 2) drain_results();
        send_access(a, 0, none);
      end
    end

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("Covered %0d results, %0d ghost hits, capacities 1 to 64 with saturation,",
             result_cnt, ghost_hit_cnt);
    $display("under free flow, sender gaps, receiver stalls and a long hold-off.");
    if (fail_cnt == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
